// ===== hdl/itra_pkg.sv =====
// Shared types, constants and the digit-to-ASCII mapping of the radix text converter.
package itra_pkg;

  localparam int NUMBER_W   = 32;
  localparam int WIDE_W     = 64;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT
  } itra_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d} - {1'b0, DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

// ===== hdl/itra_in_if.sv =====
// Input channel carrying one signed number per transfer.
interface itra_in_if
  import itra_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// ===== hdl/itra_out_if.sv =====
// Output channel carrying one ASCII character and its flags per transfer.
interface itra_out_if
  import itra_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              bad_radix;

  modport source (output valid, output character, output last, output bad_radix,
                  input ready);
  modport sink   (input valid, input character, input last, input bad_radix,
                  output ready);
endinterface

// ===== hdl/integer_to_radix_ascii.sv =====
// Top level: converts a signed integer to ASCII text in a configurable radix.
//
// Each accepted number is split into digits by one shared bit-serial divider, and
// the digits land in a small memory. They are then sent most significant first,
// after a minus sign when the number is negative: each digit is read from the
// memory, loaded into the output register and held until the sink takes it.
// The input is not ready until the last character has been transferred. A radix
// outside 2 to 36 gives one character of zero with bad_radix and last set.
module integer_to_radix_ascii
  import itra_pkg::*;
#(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               radix_wr_en,
  input  logic [RADIX_W-1:0] radix_wr_data,
  itra_in_if.sink            value,
  itra_out_if.source         text
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  itra_state_t state, state_next;

  logic [RADIX_W-1:0]    radix;
  logic                  radix_ok;
  logic [WIDE_W-1:0]     wide;
  logic [VALUE_BITS-1:0] raw;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_inc;
  logic                  in_fire;
  logic                  out_fire;
  logic                  more;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  logic                  mem_we;
  logic [DIGIT_W-1:0]    mem_rdata;

  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_last;
  logic                  out_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  assign radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign wide      = {{(WIDE_W - NUMBER_W){1'b0}}, value.number};
  assign raw       = wide[VALUE_BITS-1:0];
  assign neg_in    = raw[VALUE_BITS-1];
  assign mag       = neg_in ? (~raw + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : raw;
  assign in_fire   = value.valid && value.ready;
  assign out_fire  = out_valid && text.ready;
  assign count_inc = count + CW'(1);
  assign more      = (div_quot != '0) && (count_inc < CW'(MAX_DIGITS));

  itra_divider #(
    .W (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itra_digit_mem #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (div_rem),
    .raddr (AW'(count - CW'(1))),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = radix_ok ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done && !more) begin
          state_next = neg ? ST_SIGN : ST_FETCH;
        end
      end
      ST_SIGN: begin
        if (out_fire) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_fire) begin
          state_next = out_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    value.ready  = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    mem_we       = 1'b0;
    case (state)
      ST_IDLE: begin
        value.ready  = 1'b1;
        div_start    = in_fire && radix_ok;
        div_dividend = mag;
      end
      ST_DIV: begin
        mem_we    = div_done;
        div_start = div_done && more;
      end
      default: begin
        value.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            count <= '0;
            if (!radix_ok) begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            count <= count_inc;
            if (!more && neg) begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_LOAD: begin
          out_valid <= 1'b1;
          count     <= count - CW'(1);
        end
        ST_SIGN, ST_EMIT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          out_valid <= out_valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      neg      <= neg_in;
      out_char <= CHAR_NONE;
      out_last <= 1'b1;
      out_bad  <= 1'b1;
    end else if (state == ST_DIV && div_done) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
      out_bad  <= 1'b0;
    end else if (state == ST_LOAD) begin
      out_char <= digit_char(mem_rdata);
      out_last <= (count == CW'(1));
      out_bad  <= 1'b0;
    end
  end

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;
  assign text.bad_radix = out_bad;

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    value.ready |-> !text.valid)
    else $error("input ready while a character is pending");

  a_bad_radix_reply: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !radix_ok) |=> (text.valid && text.last && text.bad_radix))
    else $error("bad radix did not produce a flagged final character");

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_DIGITS))
    else $error("digit count beyond capacity");

  a_digit_last_on_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (text.last == ($past(count) == CW'(1))))
    else $error("last flag does not match remaining digit count");

endmodule

// ===== hdl/itra_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, small radix divisor.
module itra_divider
  import itra_pkg::*;
#(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       dividend,
  input  logic [RADIX_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [W-1:0]       quotient,
  output logic [DIGIT_W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [RADIX_W-1:0] dvsr;
  logic [W-1:0]       quot;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   diff;
  logic               fits;

  assign trial = {rem, quot[W-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (cnt != '0) begin
      quot <= {quot[W-2:0], fits};
      rem  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign busy      = (cnt != '0);
  assign quotient  = quot;
  assign remainder = rem;

endmodule

// ===== hdl/itra_digit_mem.sv =====
// Digit store: one write port, one registered read port.
module itra_digit_mem
  import itra_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
